FILE: rtl/qmeu_pkg.sv
// ----------------------------------------------------------------------------
// qmeu_pkg
// Shared types and constants of the queue machine execute unit.
// ----------------------------------------------------------------------------
package qmeu_pkg;

	localparam int QUEUE_DEPTH    = 256;
	localparam int QADDR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCOUNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int REGISTER_COUNT = 26;
	localparam int WORD_W         = 16;
	localparam int RIDX_W         = 5;

	localparam logic [4:0] F_PUSH  = 5'd0;
	localparam logic [4:0] F_ADD   = 5'd1;
	localparam logic [4:0] F_SUB   = 5'd2;
	localparam logic [4:0] F_MUL   = 5'd3;
	localparam logic [4:0] F_DIV   = 5'd4;
	localparam logic [4:0] F_MOD   = 5'd5;
	localparam logic [4:0] F_STORE = 5'd6;
	localparam logic [4:0] F_LOAD  = 5'd7;
	localparam logic [4:0] F_PNQ   = 5'd8;
	localparam logic [4:0] F_PNR   = 5'd9;
	localparam logic [4:0] F_PCQ   = 5'd10;
	localparam logic [4:0] F_PCR   = 5'd11;
	localparam logic [4:0] F_JMP   = 5'd12;
	localparam logic [4:0] F_JZ    = 5'd13;
	localparam logic [4:0] F_JE    = 5'd14;
	localparam logic [4:0] F_JG    = 5'd15;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NUM  = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP1,
		S_POP2,
		S_DIV,
		S_DONE,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;      // capture the instruction
		logic rd_front;   // start a read of the queue front
		logic take_x;     // capture read data as left operand, pop
		logic take_y;     // capture read data as right operand, pop
		logic div_start;
		logic div_step;
		logic finish;     // commit result and load output register
		logic out_taken;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [4:0] func;
		logic       q_empty;
		logic       q_lt2;
		logic       div_last;
	} sts_t;

endpackage

FILE: rtl/qmeu_datapath.sv
// ----------------------------------------------------------------------------
// qmeu_datapath
// Queue memory, register file, program counter, iterative divider and the
// output word register.
// ----------------------------------------------------------------------------
module qmeu_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qmeu_pkg::cmd_t              cmd,
	output qmeu_pkg::sts_t              sts,
	input  logic [4:0]                  func,
	input  logic [4:0]                  reg_first,
	input  logic [4:0]                  reg_second,
	input  logic [15:0]                 immediate,
	input  logic [15:0]                 jump_target,
	output logic [1:0]                  out_kind,
	output logic [15:0]                 out_value,
	output logic [15:0]                 next_address,
	output logic [1:0]                  status
);

	logic [15:0] mem [qmeu_pkg::QUEUE_DEPTH];
	logic [15:0] rd_data_q;
	logic [qmeu_pkg::QADDR_W-1:0]  head_q;
	logic [qmeu_pkg::QCOUNT_W-1:0] count_q;
	logic [15:0] regs_q [qmeu_pkg::REGISTER_COUNT];
	logic [15:0] pc_q;

	logic [4:0]  func_q, ra_q, rb_q;
	logic [15:0] imm_q, tgt_q;
	logic [15:0] x_q, y_q;
	logic [15:0] rem_q, quo_q;
	logic [4:0]  div_cnt_q;
	logic [15:0] prod_s1;
	logic        err_q;
	logic        sts_err_set;

	logic [15:0] ra_val, rb_val;
	logic        q_full;
	logic        do_push, do_pop;
	logic [15:0] push_val;
	logic [qmeu_pkg::QADDR_W-1:0] tail;
	logic [qmeu_pkg::QADDR_W-1:0] rd_addr;
	logic [16:0] trial;
	logic [15:0] rem_sh;

	assign ra_val = (ra_q < 5'(qmeu_pkg::REGISTER_COUNT)) ? regs_q[ra_q] : 16'd0;
	assign rb_val = (rb_q < 5'(qmeu_pkg::REGISTER_COUNT)) ? regs_q[rb_q] : 16'd0;
	assign q_full = (count_q == qmeu_pkg::QCOUNT_W'(qmeu_pkg::QUEUE_DEPTH));
	assign tail   = head_q + count_q[qmeu_pkg::QADDR_W-1:0];

	// The second operand read is issued while the first word is being popped,
	// so it looks one entry past the current head.
	assign rd_addr = cmd.take_x ? (head_q + qmeu_pkg::QADDR_W'(1)) : head_q;

	assign sts.func     = func_q;
	assign sts.q_empty  = (count_q == '0);
	assign sts.q_lt2    = (count_q < qmeu_pkg::QCOUNT_W'(2));
	assign sts.div_last = (div_cnt_q == 5'd15);

	// Restoring division, one quotient bit a step.
	assign rem_sh = {rem_q[14:0], quo_q[15]};
	assign trial  = {rem_q, quo_q[15]} - {1'b0, y_q};

	// Result of an instruction at finish.
	logic [15:0] alu_r;
	always_comb begin
		case (func_q)
			qmeu_pkg::F_ADD: alu_r = x_q + y_q;
			qmeu_pkg::F_SUB: alu_r = x_q - y_q;
			qmeu_pkg::F_MUL: alu_r = prod_s1;
			qmeu_pkg::F_DIV: alu_r = (y_q == '0) ? 16'd0 : quo_q;
			qmeu_pkg::F_MOD: alu_r = (y_q == '0) ? 16'd0 : rem_q;
			default:         alu_r = 16'd0;
		endcase
	end

	logic        is_arith, is_pushop, is_popq;
	logic [1:0]  st_c;
	logic [1:0]  kind_c;
	logic [15:0] val_c;
	logic        taken_c;
	always_comb begin
		is_arith  = (func_q >= qmeu_pkg::F_ADD) && (func_q <= qmeu_pkg::F_MOD);
		is_pushop = (func_q == qmeu_pkg::F_PUSH) || (func_q == qmeu_pkg::F_LOAD);
		is_popq   = (func_q == qmeu_pkg::F_STORE) || (func_q == qmeu_pkg::F_PNQ) ||
			(func_q == qmeu_pkg::F_PCQ);
		st_c      = qmeu_pkg::ST_OK;
		kind_c    = qmeu_pkg::KIND_NONE;
		val_c     = 16'd0;
		taken_c   = 1'b0;
		push_val  = (func_q == qmeu_pkg::F_PUSH) ? imm_q : ra_val;
		if (is_arith) begin
			push_val = alu_r;
		end
		if (is_pushop && q_full) begin
			st_c = qmeu_pkg::ST_FULL;
		end
		// Arithmetic with too few words and empty pops were flagged before the
		// pops; the controller only skips them, so the status comes from err_q.
		case (func_q)
			qmeu_pkg::F_PNQ: begin
				kind_c = qmeu_pkg::KIND_NUM;
				val_c  = x_q;
			end
			qmeu_pkg::F_PNR: begin
				kind_c = qmeu_pkg::KIND_NUM;
				val_c  = ra_val;
			end
			qmeu_pkg::F_PCQ: begin
				kind_c = qmeu_pkg::KIND_CHAR;
				val_c  = {8'd0, x_q[7:0]};
			end
			qmeu_pkg::F_PCR: begin
				kind_c = qmeu_pkg::KIND_CHAR;
				val_c  = {8'd0, ra_val[7:0]};
			end
			qmeu_pkg::F_JMP: taken_c = 1'b1;
			qmeu_pkg::F_JZ:  taken_c = (ra_val == '0);
			qmeu_pkg::F_JE:  taken_c = (ra_val == rb_val);
			qmeu_pkg::F_JG:  taken_c = (ra_val > rb_val);
			default: ;
		endcase
		if (err_q) begin
			st_c   = qmeu_pkg::ST_EMPTY;
			kind_c = qmeu_pkg::KIND_NONE;
			val_c  = 16'd0;
		end
	end

	assign do_push = cmd.finish && !err_q && (is_arith || (is_pushop && !q_full));
	assign do_pop  = cmd.take_x || cmd.take_y;

	always_ff @(posedge clk) begin
		if (cmd.rd_front) begin
			rd_data_q <= mem[rd_addr];
		end
		if (do_push) begin
			mem[tail] <= push_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			ra_q   <= reg_first;
			rb_q   <= reg_second;
			imm_q  <= immediate;
			tgt_q  <= jump_target;
		end
		if (cmd.take_x) begin
			x_q <= rd_data_q;
		end
		if (cmd.take_y) begin
			y_q <= rd_data_q;
		end
		prod_s1 <= x_q * y_q;
		if (cmd.div_start) begin
			rem_q     <= 16'd0;
			quo_q     <= x_q;
			div_cnt_q <= 5'd0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 5'd1;
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			pc_q         <= '0;
			err_q        <= 1'b0;
			out_kind     <= '0;
			out_value    <= '0;
			next_address <= '0;
			status       <= '0;
			for (int i = 0; i < qmeu_pkg::REGISTER_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (cmd.latch) begin
				err_q <= 1'b0;
			end else if (sts_err_set) begin
				err_q <= 1'b1;
			end
			if (do_pop && !do_push) begin
				head_q  <= head_q + qmeu_pkg::QADDR_W'(1);
				count_q <= count_q - qmeu_pkg::QCOUNT_W'(1);
			end else if (do_push) begin
				count_q <= count_q + qmeu_pkg::QCOUNT_W'(1);
			end
			if (cmd.finish) begin
				if (func_q == qmeu_pkg::F_STORE && !err_q &&
					ra_q < 5'(qmeu_pkg::REGISTER_COUNT)) begin
					regs_q[ra_q] <= x_q;
				end
				pc_q         <= (taken_c ? tgt_q : pc_q) + 16'd1;
				next_address <= (taken_c ? tgt_q : pc_q) + 16'd1;
				out_kind     <= kind_c;
				out_value    <= val_c;
				status       <= st_c;
			end
		end
	end

	// The error flag is raised in the first step after capture.
	assign sts_err_set = cmd.rd_front && ((is_arith && sts.q_lt2) ||
		(is_popq && sts.q_empty));

endmodule

FILE: rtl/qmeu_ctrl.sv
// ----------------------------------------------------------------------------
// qmeu_ctrl
// Sequencer: pops operands, runs the divider and hands out the result word.
// ----------------------------------------------------------------------------
module qmeu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  qmeu_pkg::sts_t sts,
	output qmeu_pkg::cmd_t cmd
);

	qmeu_pkg::state_t state_q, state_d;
	logic arith, popq, need_pop, skip;
	// div_go_q marks that the divider was started and is stepping.
	logic div_go_q, y_pending_q;

	always_comb begin
		arith  = (sts.func >= qmeu_pkg::F_ADD) && (sts.func <= qmeu_pkg::F_MOD);
		popq   = (sts.func == qmeu_pkg::F_STORE) || (sts.func == qmeu_pkg::F_PNQ) ||
			(sts.func == qmeu_pkg::F_PCQ);
		need_pop = arith || popq;
		skip   = arith ? sts.q_lt2 : sts.q_empty;
	end

	// S_IDLE latches the instruction and moves to S_POP1, which issues the read.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qmeu_pkg::S_IDLE: if (in_valid) state_d = qmeu_pkg::S_POP1;
			qmeu_pkg::S_POP1: begin
				if (!need_pop || skip) state_d = qmeu_pkg::S_DONE;
				else                   state_d = qmeu_pkg::S_POP2;
			end
			qmeu_pkg::S_POP2: begin
				if (!arith) state_d = qmeu_pkg::S_DONE;
				else        state_d = qmeu_pkg::S_DIV;
			end
			qmeu_pkg::S_DIV: begin
				// Add, subtract and multiply stay in S_DIV past the second pop until
				// y_pending_q clears, so that the product register sees both operands.
				if (sts.func != qmeu_pkg::F_DIV && sts.func != qmeu_pkg::F_MOD) begin
					if (!y_pending_q) state_d = qmeu_pkg::S_DONE;
				end else if (div_go_q && sts.div_last)
					state_d = qmeu_pkg::S_DONE;
			end
			qmeu_pkg::S_DONE: state_d = qmeu_pkg::S_OUT;
			qmeu_pkg::S_OUT:  if (!out_stall) state_d = qmeu_pkg::S_IDLE;
			default: state_d = qmeu_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = (state_q != qmeu_pkg::S_IDLE);
		out_valid = (state_q == qmeu_pkg::S_OUT);
		unique case (state_q)
			qmeu_pkg::S_IDLE: cmd.latch = in_valid;
			qmeu_pkg::S_POP1: begin
				cmd.rd_front = 1'b1;
			end
			qmeu_pkg::S_POP2: begin
				cmd.take_x   = 1'b1;
				cmd.rd_front = arith;
			end
			qmeu_pkg::S_DIV: begin
				cmd.take_y    = y_pending_q;
				cmd.div_start = !y_pending_q && !div_go_q;
				cmd.div_step  = div_go_q;
			end
			qmeu_pkg::S_DONE: cmd.finish = 1'b1;
			qmeu_pkg::S_OUT:  cmd.out_taken = !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qmeu_pkg::S_IDLE;
			div_go_q    <= 1'b0;
			y_pending_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == qmeu_pkg::S_POP2) begin
				y_pending_q <= arith;
				div_go_q    <= 1'b0;
			end else if (state_q == qmeu_pkg::S_DIV) begin
				y_pending_q <= 1'b0;
				if (cmd.div_start) div_go_q <= 1'b1;
			end
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result shown while accepting");
	a_finish_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid) else $error("finish not followed by output");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> (state_q == qmeu_pkg::S_POP1)) else $error("bad start");

endmodule

FILE: rtl/queue_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// queue_machine_execute_unit
// Executes one decoded queue machine instruction per input word.
// ----------------------------------------------------------------------------
// One instruction word is taken at a time and gives one result word. Push,
// load, jumps, prints from a register and no-ops go straight from S_POP1 to
// S_DONE; store and prints from the queue add S_POP2; add, subtract and
// multiply add S_DIV as well, and divide and modulo, whose 16-step restoring
// divider runs in S_DIV, take longest. Once the result word is taken the
// block returns to S_IDLE before the next word is accepted.
// Operand pops read the queue memory through one registered read port, one
// word a cycle.
module queue_machine_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  func,
	input  logic [4:0]  reg_first,
	input  logic [4:0]  reg_second,
	input  logic [15:0] immediate,
	input  logic [15:0] jump_target,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [15:0] out_value,
	output logic [15:0] next_address,
	output logic [1:0]  status
);

	qmeu_pkg::cmd_t cmd;
	qmeu_pkg::sts_t sts;

	qmeu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	qmeu_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.reg_first    (reg_first),
		.reg_second   (reg_second),
		.immediate    (immediate),
		.jump_target  (jump_target),
		.out_kind     (out_kind),
		.out_value    (out_value),
		.next_address (next_address),
		.status       (status)
	);

endmodule

FILE: bench/qmeu_checker.sv
// ----------------------------------------------------------------------------
// qmeu_checker
// Watches both channels of the queue machine execute unit, runs each accepted
// instruction word through a model of the machine and compares result words.
// ----------------------------------------------------------------------------
module qmeu_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [4:0]  func,
	input  logic [4:0]  reg_first,
	input  logic [4:0]  reg_second,
	input  logic [15:0] immediate,
	input  logic [15:0] jump_target,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  out_kind,
	input  logic [15:0] out_value,
	input  logic [15:0] next_address,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic [15:0] next_pc;
		logic [1:0]  st;
	} result_t;

	result_t     expected_results[$];
	logic [15:0] fifo_words[qmeu_pkg::QUEUE_DEPTH];
	int          fifo_head;
	int          fifo_fill;
	logic [15:0] regs[qmeu_pkg::REGISTER_COUNT];
	logic [15:0] pc;

	function automatic logic [15:0] read_reg(logic [4:0] idx);
		return (idx < qmeu_pkg::REGISTER_COUNT) ? regs[idx] : 16'd0;
	endfunction

	function automatic logic [15:0] pop_word();
		logic [15:0] w;
		w = fifo_words[fifo_head];
		fifo_head = (fifo_head + 1) % qmeu_pkg::QUEUE_DEPTH;
		fifo_fill--;
		return w;
	endfunction

	function automatic void push_word(logic [15:0] w);
		fifo_words[(fifo_head + fifo_fill) % qmeu_pkg::QUEUE_DEPTH] = w;
		fifo_fill++;
	endfunction

	function automatic result_t execute_instruction(logic [4:0] f, logic [4:0] ra,
			logic [4:0] rb, logic [15:0] imm, logic [15:0] tgt);
		result_t     r;
		logic [15:0] x, y, v;
		logic        taken;
		r = '0;
		taken = 1'b0;
		case (f)
			qmeu_pkg::F_PUSH, qmeu_pkg::F_LOAD: begin
				v = (f == qmeu_pkg::F_PUSH) ? imm : read_reg(ra);
				if (fifo_fill >= qmeu_pkg::QUEUE_DEPTH) r.st = qmeu_pkg::ST_FULL;
				else push_word(v);
			end
			qmeu_pkg::F_ADD, qmeu_pkg::F_SUB, qmeu_pkg::F_MUL, qmeu_pkg::F_DIV,
			qmeu_pkg::F_MOD: begin
				if (fifo_fill < 2) begin
					r.st = qmeu_pkg::ST_EMPTY;
				end else begin
					x = pop_word();
					y = pop_word();
					case (f)
						qmeu_pkg::F_ADD: v = x + y;
						qmeu_pkg::F_SUB: v = x - y;
						qmeu_pkg::F_MUL: v = x * y;
						qmeu_pkg::F_DIV: v = (y == 0) ? 16'd0 : x / y;
						default: v = (y == 0) ? 16'd0 : x % y;
					endcase
					push_word(v);
				end
			end
			qmeu_pkg::F_STORE: begin
				if (fifo_fill == 0) r.st = qmeu_pkg::ST_EMPTY;
				else begin
					v = pop_word();
					if (ra < qmeu_pkg::REGISTER_COUNT) regs[ra] = v;
				end
			end
			qmeu_pkg::F_PNQ, qmeu_pkg::F_PNR, qmeu_pkg::F_PCQ, qmeu_pkg::F_PCR: begin
				if ((f == qmeu_pkg::F_PNQ || f == qmeu_pkg::F_PCQ) && fifo_fill == 0) begin
					r.st = qmeu_pkg::ST_EMPTY;
				end else begin
					v = (f == qmeu_pkg::F_PNQ || f == qmeu_pkg::F_PCQ) ? pop_word()
						: read_reg(ra);
					if (f >= qmeu_pkg::F_PCQ) begin
						r.kind = qmeu_pkg::KIND_CHAR;
						r.value = {8'd0, v[7:0]};
					end else begin
						r.kind = qmeu_pkg::KIND_NUM;
						r.value = v;
					end
				end
			end
			qmeu_pkg::F_JMP: taken = 1'b1;
			qmeu_pkg::F_JZ:  taken = (read_reg(ra) == 16'd0);
			qmeu_pkg::F_JE:  taken = (read_reg(ra) == read_reg(rb));
			qmeu_pkg::F_JG:  taken = (read_reg(ra) > read_reg(rb));
			default: ;
		endcase
		pc = (taken ? tgt : pc) + 16'd1;
		r.next_pc = pc;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			expected_results.delete();
			fifo_head = 0;
			fifo_fill = 0;
			pc = '0;
			fail_count = 0;
			for (int i = 0; i < qmeu_pkg::REGISTER_COUNT; i++) regs[i] = '0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result word with none expected", $realtime);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.kind !== out_kind || exp_r.value !== out_value ||
							exp_r.next_pc !== next_address || exp_r.st !== status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: kind/value/next/status exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$realtime, exp_r.kind, exp_r.value, exp_r.next_pc, exp_r.st,
								out_kind, out_value, next_address, status);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(),
					execute_instruction(func, reg_first, reg_second, immediate,
					jump_target));
		end
		pending_results = expected_results.size();
	end
endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives instruction words into the queue machine execute unit with random
// gaps and result stalls; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [4:0] F_NOP = 5'd16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [4:0]  func = '0;
	logic [4:0]  reg_first = '0;
	logic [4:0]  reg_second = '0;
	logic [15:0] immediate = '0;
	logic [15:0] jump_target = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [1:0]  out_kind;
	logic [15:0] out_value;
	logic [15:0] next_address;
	logic [1:0]  status;
	int          fail_count;
	int          pending_results;
	// The sender raises this once its words are done, so the receiver stops.
	bit          sending_done = 1'b0;
	// Set while the receiver's long hold-off should happen.
	bit          long_hold_req = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	queue_machine_execute_unit u_dut (.*);

	qmeu_checker u_checker (.*);

	// Sends one instruction word: waits a random gap with valid low, offers
	// the word at a falling edge and holds it until a rising edge accepts it.
	// Valid stays high on return so that a word with no gap follows directly.
	task automatic send_word(logic [4:0] f, logic [4:0] ra, logic [4:0] rb,
			logic [15:0] imm, logic [15:0] tgt, bit no_gap = 1'b0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= f;
		reg_first <= ra;
		reg_second <= rb;
		immediate <= imm;
		jump_target <= tgt;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// A mostly legal register index; rarely one above 25, which reads as zero.
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 19) == 0) ? 5'($urandom_range(26, 31))
			: 5'($urandom_range(0, 25));
	endfunction

	// Random operand words lean toward the edges so that overflow, zero
	// divisors and all bits are reached.
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 7));
			default: return 16'($urandom);
		endcase
	endfunction

	// Receiver: draws a stall for every word, with calm words for which it
	// never stalls, and one long hold-off on request.
	initial begin
		int wait_cycles;
		bit calm;
		@(posedge arst_n);
		while (!sending_done) begin
			@(negedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				long_hold_req = 1'b0;
			end
			calm = ($urandom_range(0, 7) == 0);
			wait_cycles = calm ? 0 : $urandom_range(0, 15);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles - 1) @(negedge clk);
				@(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
		@(negedge clk);
		out_stall <= 1'b0;
	end

	initial begin
		int pick;
		int waited;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty-queue errors, every operation, the extreme
		// words, zero divisors, bad register indexes and unknown operations.
		send_word(qmeu_pkg::F_ADD, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_STORE, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PCQ, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PUSH, 5'd0, 5'd0, 16'hFFFF, 16'd0);
		send_word(qmeu_pkg::F_SUB, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PUSH, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_DIV, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PUSH, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_MOD, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PUSH, 5'd0, 5'd0, 16'hFFFF, 16'd0);
		send_word(qmeu_pkg::F_MUL, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_STORE, 5'd25, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_LOAD, 5'd25, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PUSH, 5'd0, 5'd0, 16'd7, 16'd0);
		send_word(qmeu_pkg::F_MOD, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PNQ, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PNR, 5'd25, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_PCR, 5'd31, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_JMP, 5'd0, 5'd0, 16'd0, 16'hFFFF);
		send_word(qmeu_pkg::F_JZ, 5'd0, 5'd0, 16'd0, 16'h5555);
		send_word(qmeu_pkg::F_JE, 5'd25, 5'd0, 16'd0, 16'hAAAA);
		send_word(qmeu_pkg::F_JG, 5'd25, 5'd31, 16'd0, 16'd3);
		send_word(F_NOP, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF);
		send_word(5'd31, 5'd0, 5'd0, 16'd0, 16'd0);
		send_word(qmeu_pkg::F_STORE, 5'd30, 5'd0, 16'd0, 16'd0);

		// Fill the queue to overflow while the receiver holds off, so the
		// block backs up and stalls its input; then drain it with arithmetic
		// down to one word, which the last two prints take and then miss.
		long_hold_req = 1'b1;
		for (int i = 0; i < qmeu_pkg::QUEUE_DEPTH + 3; i++)
			send_word(qmeu_pkg::F_PUSH, 5'd0, 5'd0, 16'($urandom), 16'd0, 1'b1);
		send_word(qmeu_pkg::F_LOAD, 5'd3, 5'd0, 16'd0, 16'd0);
		for (int i = 0; i < qmeu_pkg::QUEUE_DEPTH + 1; i++)
			send_word(5'($urandom_range(1, 5)), 5'd0, 5'd0, 16'd0, 16'd0, 1'b1);
		repeat (2) send_word(qmeu_pkg::F_PNQ, 5'd0, 5'd0, 16'd0, 16'd0, 1'b1);

		// Random part: a random mix of pushes and loads, arithmetic, stores,
		// prints and jumps, with some unknown operations mixed in.
		for (int n = 0; n < 1050; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				send_word(qmeu_pkg::F_PUSH, pick_reg(), pick_reg(), pick_word(),
					16'($urandom));
			else if (pick < 38)
				send_word(qmeu_pkg::F_LOAD, pick_reg(), pick_reg(), 16'($urandom),
					16'($urandom));
			else if (pick < 60)
				send_word(5'($urandom_range(1, 5)), pick_reg(), pick_reg(),
					16'($urandom), 16'($urandom));
			else if (pick < 70)
				send_word(qmeu_pkg::F_STORE, pick_reg(), pick_reg(), 16'($urandom),
					16'($urandom));
			else if (pick < 82)
				send_word(5'($urandom_range(8, 11)), pick_reg(), pick_reg(),
					16'($urandom), 16'($urandom));
			else if (pick < 96)
				send_word(5'($urandom_range(12, 15)), pick_reg(), pick_reg(),
					16'($urandom), 16'($urandom));
			else
				send_word(5'($urandom_range(16, 31)), 5'($urandom), 5'($urandom),
					16'($urandom), 16'($urandom));
		end
		in_valid <= 1'b0;

		waited = 0;
		while (pending_results != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
		sending_done = 1'b1;
		if (fail_count == 0 && pending_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
